/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ntc_pkg.sv */
`default_nettype none

package ntc_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int CHANNEL_W    = 5;
   localparam int TEMP_W       = 7;
   localparam int STATUS_W     = 2;

   localparam int SAMPLES_AVERAGED_DEF = 8;
   localparam int TABLE_POINTS         = 11;
   localparam int DEGREES_PER_STEP     = 10;
   localparam int INDEX_W              = $clog2(TABLE_POINTS);
   localparam int TEMP_MAX             = (TABLE_POINTS - 1) * DEGREES_PER_STEP;
   localparam int QUEUE_DEPTH          = 2;

   // Divider reading at each table point, descending, one point per step.
   localparam logic [SAMPLE_W-1:0] POINT_READING [TABLE_POINTS] = '{
      12'd3424, 12'd2987, 12'd2467, 12'd1930, 12'd1443, 12'd1040,
      12'd731,  12'd508,  12'd350,  12'd240,  12'd165
   };

   localparam int PROD_W = $clog2(int'(POINT_READING[0]) * DEGREES_PER_STEP + 1);

   localparam logic [STATUS_W-1:0] STATUS_INTERP = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_COLD   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HOT    = 2'd2;

   function automatic int sum_width(input int n);
      return $clog2(((1 << SAMPLE_W) - 1) * n + 1);
   endfunction

endpackage

`default_nettype wire

/* src/ntc_front.sv */
`default_nettype none

module ntc_front #(
   parameter int SAMPLES_AVERAGED = ntc_pkg::SAMPLES_AVERAGED_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_push,
   output logic                                             req_full,
   input  logic [ntc_pkg::SAMPLE_W-1:0]                     req_sample,
   input  logic [ntc_pkg::CHANNEL_W-1:0]                    req_channel,
   input  logic                                             req_restart,
   output logic                                             q_push,
   input  logic                                             q_full,
   output logic [ntc_pkg::sum_width(SAMPLES_AVERAGED)-1:0] q_sum,
   output logic [ntc_pkg::CHANNEL_W-1:0]                    q_channel
);
   import ntc_pkg::*;

   localparam int SUM_W = sum_width(SAMPLES_AVERAGED);
   localparam int POS_W = $clog2(SAMPLES_AVERAGED + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic             accept, discard, last;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign discard  = req_restart || (pos_ff == '0);
   assign last     = (pos_ff == POS_W'(SAMPLES_AVERAGED));
   assign sum_add  = sum_ff + SUM_W'(req_sample);

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (discard) begin
            pos_in = POS_W'(1);
            sum_in = '0;
         end else if (last) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            sum_in = sum_add;
         end
      end
   end

   assign q_push    = accept && !discard && last;
   assign q_sum     = sum_add;
   assign q_channel = req_channel;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

/* src/ntc_fifo.sv */
`default_nettype none

module ntc_fifo #(
   parameter int WIDTH = ntc_pkg::CHANNEL_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   import ntc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* src/ntc_back.sv */
`default_nettype none

module ntc_back #(
   parameter int SAMPLES_AVERAGED = ntc_pkg::SAMPLES_AVERAGED_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             q_empty,
   output logic                                             q_pop,
   input  logic [ntc_pkg::sum_width(SAMPLES_AVERAGED)-1:0] q_sum,
   input  logic [ntc_pkg::CHANNEL_W-1:0]                    q_channel,
   output logic                                             rsp_empty,
   input  logic                                             rsp_pop,
   output logic [ntc_pkg::TEMP_W-1:0]                       rsp_temperature,
   output logic [ntc_pkg::SAMPLE_W-1:0]                     rsp_average_reading,
   output logic [ntc_pkg::STATUS_W-1:0]                     rsp_range_status,
   output logic [ntc_pkg::CHANNEL_W-1:0]                    rsp_channel_tag
);
   import ntc_pkg::*;

   localparam int SUM_W = sum_width(SAMPLES_AVERAGED);
   localparam int DIV_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int CNT_W = $clog2(DIV_W + 1);

   // average by reciprocal multiplication, exact for every sum below 2**SUM_W
   localparam int AVG_SH  = SUM_W + $clog2(SAMPLES_AVERAGED);
   localparam int AVG_MUL = ((1 << AVG_SH) + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED;
   localparam int MUL_W   = SUM_W + 2;
   localparam int AVGP_W  = SUM_W + MUL_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_AVG    = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_PREP   = 6'b001000,
      ST_INTERP = 6'b010000,
      ST_DONE   = 6'b100000
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [DIV_W-1:0]      dvd_ff, dvd_in;
   logic [SAMPLE_W-1:0]   rem_ff, rem_in;
   logic [SAMPLE_W-1:0]   dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0]   avg_ff, avg_in;
   logic [CHANNEL_W-1:0]  ch_ff, ch_in;
   logic [INDEX_W-1:0]    seg_ff, seg_in;
   logic [TEMP_W-1:0]     temp_ff, temp_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  out_valid_ff, out_valid_in;
   logic [TEMP_W-1:0]     out_temp_ff;
   logic [SAMPLE_W-1:0]   out_avg_ff;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [CHANNEL_W-1:0]  out_ch_ff;

   // one restoring-division step
   logic [SAMPLE_W:0]     shifted, diff;
   logic                  qbit;
   logic [DIV_W-1:0]      step_dvd;
   logic [SAMPLE_W-1:0]   step_rem;

   logic [AVGP_W-1:0]     avg_prod;
   logic                  found;
   logic [INDEX_W-1:0]    seg_hit;
   logic [SAMPLE_W-1:0]   hi, lo, span;
   logic [PROD_W-1:0]     prod;
   logic [TEMP_W-1:0]     seg_temp;
   logic                  load_out;

   assign shifted  = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff     = shifted - {1'b0, dsr_ff};
   assign qbit     = (shifted >= {1'b0, dsr_ff});
   assign step_rem = qbit ? diff[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
   assign step_dvd = {dvd_ff[DIV_W-2:0], qbit};

   assign avg_prod = AVGP_W'(dvd_ff[SUM_W-1:0]) * AVGP_W'(AVG_MUL);

   always_comb begin
      found   = 1'b0;
      seg_hit = '0;
      for (int k = 0; k < TABLE_POINTS - 1; k++) begin
         if (!found && (avg_ff <= POINT_READING[k]) && (avg_ff > POINT_READING[k+1])) begin
            found   = 1'b1;
            seg_hit = INDEX_W'(k);
         end
      end
   end

   assign hi       = POINT_READING[seg_ff];
   assign lo       = POINT_READING[seg_ff + INDEX_W'(1)];
   assign span     = hi - lo;
   assign prod     = PROD_W'(hi - avg_ff) * PROD_W'(DEGREES_PER_STEP);
   assign seg_temp = TEMP_W'(seg_ff) * TEMP_W'(DEGREES_PER_STEP);
   assign load_out = (state_ff == ST_DONE) && (!out_valid_ff || rsp_pop);

   always_comb begin
      state_in  = state_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      avg_in    = avg_ff;
      ch_in     = ch_ff;
      seg_in    = seg_ff;
      temp_in   = temp_ff;
      status_in = status_ff;
      q_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               dvd_in   = DIV_W'(q_sum);
               ch_in    = q_channel;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            avg_in   = avg_prod[AVG_SH +: SAMPLE_W];
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (avg_ff >= POINT_READING[0]) begin
               temp_in   = '0;
               status_in = STATUS_COLD;
               state_in  = ST_DONE;
            end else if (avg_ff <= POINT_READING[TABLE_POINTS-1]) begin
               temp_in   = TEMP_W'(TEMP_MAX);
               status_in = STATUS_HOT;
               state_in  = ST_DONE;
            end else if (found) begin
               seg_in   = seg_hit;
               state_in = ST_PREP;
            end else begin
               temp_in   = '0;
               status_in = STATUS_INTERP;
               state_in  = ST_DONE;
            end
         end
         ST_PREP: begin
            status_in = STATUS_INTERP;
            if (span == '0) begin
               temp_in  = seg_temp;
               state_in = ST_DONE;
            end else begin
               dvd_in   = DIV_W'(prod);
               dsr_in   = span;
               rem_in   = '0;
               cnt_in   = CNT_W'(DIV_W);
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: begin
            if (cnt_ff == '0) begin
               temp_in  = seg_temp + dvd_ff[TEMP_W-1:0];
               state_in = ST_DONE;
            end else begin
               dvd_in = step_dvd;
               rem_in = step_rem;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      dsr_ff    <= dsr_in;
      cnt_ff    <= cnt_in;
      avg_ff    <= avg_in;
      ch_ff     <= ch_in;
      seg_ff    <= seg_in;
      temp_ff   <= temp_in;
      status_ff <= status_in;
      if (load_out) begin
         out_temp_ff   <= temp_ff;
         out_avg_ff    <= avg_ff;
         out_status_ff <= status_ff;
         out_ch_ff     <= ch_ff;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_temperature     = out_temp_ff;
   assign rsp_average_reading = out_avg_ff;
   assign rsp_range_status    = out_status_ff;
   assign rsp_channel_tag     = out_ch_ff;

endmodule

`default_nettype wire

/* src/ntc_average_and_lut_temperature_top.sv */
`default_nettype none

// Thermistor averaging and temperature conversion. Samples are taken one per
// cycle while req_full is low; each burst of SAMPLES_AVERAGED + 1 samples
// drops its first sample, sums the rest and hands the sum, with the channel of
// the last sample, to a two-item queue. The converter pops one item at a time:
// a multiply by the reciprocal of SAMPLES_AVERAGED forms the average, a table
// search picks the segment, and a restoring divider (one quotient bit per
// cycle) does the interpolation; a clamped reading skips the divider. A result
// waits in an output register until popped, and the converter holds its next
// result until that register is free. req_full is high while the queue holds
// two bursts, which happens when bursts arrive faster than one per conversion
// time. restart drops the partial burst and the sample it comes with starts a
// new burst as its discarded first sample. Status: 0 interpolated, 1 cold or
// open sensor (temperature 0), 2 hot or shorted sensor (temperature 100).
module ntc_average_and_lut_temperature_top #(
   parameter int SAMPLES_AVERAGED = ntc_pkg::SAMPLES_AVERAGED_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [ntc_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic [ntc_pkg::CHANNEL_W-1:0]  req_channel,
   input  logic                           req_restart,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [ntc_pkg::TEMP_W-1:0]     rsp_temperature,
   output logic [ntc_pkg::SAMPLE_W-1:0]   rsp_average_reading,
   output logic [ntc_pkg::STATUS_W-1:0]   rsp_range_status,
   output logic [ntc_pkg::CHANNEL_W-1:0]  rsp_channel_tag
);
   import ntc_pkg::*;

   localparam int SUM_W = sum_width(SAMPLES_AVERAGED);
   localparam int ITEM_W = SUM_W + CHANNEL_W;

   logic                 f_push, f_full, b_pop, b_empty;
   logic [SUM_W-1:0]     f_sum, b_sum;
   logic [CHANNEL_W-1:0] f_channel, b_channel;

   ntc_front #(
      .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_sample  (req_sample),
      .req_channel (req_channel),
      .req_restart (req_restart),
      .q_push      (f_push),
      .q_full      (f_full),
      .q_sum       (f_sum),
      .q_channel   (f_channel)
   );

   ntc_fifo #(
      .WIDTH(ITEM_W)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .full  (f_full),
      .wdata ({f_sum, f_channel}),
      .pop   (b_pop),
      .empty (b_empty),
      .rdata ({b_sum, b_channel})
   );

   ntc_back #(
      .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (b_empty),
      .q_pop               (b_pop),
      .q_sum               (b_sum),
      .q_channel           (b_channel),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_temperature     (rsp_temperature),
      .rsp_average_reading (rsp_average_reading),
      .rsp_range_status    (rsp_range_status),
      .rsp_channel_tag     (rsp_channel_tag)
   );

endmodule

`default_nettype wire

/* src/ntc_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module ntc_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_push,
   input wire                           req_full,
   input wire [ntc_pkg::SAMPLE_W-1:0]   req_sample,
   input wire [ntc_pkg::CHANNEL_W-1:0]  req_channel,
   input wire                           req_restart,
   input wire                           rsp_empty,
   input wire                           rsp_pop,
   input wire [ntc_pkg::TEMP_W-1:0]     rsp_temperature,
   input wire [ntc_pkg::SAMPLE_W-1:0]   rsp_average_reading,
   input wire [ntc_pkg::STATUS_W-1:0]   rsp_range_status,
   input wire [ntc_pkg::CHANNEL_W-1:0]  rsp_channel_tag
);
   import ntc_pkg::*;

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty && !req_full, "not empty after reset")
   `ASSERT_CLK(a_cold_zero, clock, reset, (!rsp_empty && rsp_range_status == STATUS_COLD) |-> (rsp_temperature == '0), "cold item with nonzero temperature")
   `ASSERT_CLK(a_hot_max, clock, reset, (!rsp_empty && rsp_range_status == STATUS_HOT) |-> (rsp_temperature == TEMP_W'(TEMP_MAX)), "hot item not at maximum")
   `ASSERT_CLK(a_interp_range, clock, reset, (!rsp_empty && rsp_range_status == STATUS_INTERP) |-> (rsp_temperature < TEMP_W'(TEMP_MAX)), "interpolated temperature out of range")
   `ASSERT_CLK(a_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_average_reading) && $stable(rsp_channel_tag)), "waiting item changed")

endmodule

bind ntc_average_and_lut_temperature_top ntc_checker u_ntc_checker (.*);

`default_nettype wire

/* test/tb_ntc_average_and_lut_temperature_top.sv */
`default_nettype none

module tb_ntc_average_and_lut_temperature_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ntc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 1500;
   localparam int BURST_LEN    = SAMPLES_AVERAGED_DEF + 1;

   typedef struct {
      logic [SAMPLE_W-1:0]  sample;
      logic [CHANNEL_W-1:0] channel;
      logic                 restart;
      bit                   hold;
   } sample_item_type;

   typedef struct {
      logic [TEMP_W-1:0]    temperature;
      logic [SAMPLE_W-1:0]  average;
      logic [STATUS_W-1:0]  status;
      logic [CHANNEL_W-1:0] channel;
   } reading_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [SAMPLE_W-1:0]  req_sample = '0;
   logic [CHANNEL_W-1:0] req_channel = '0;
   logic                 req_restart = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [TEMP_W-1:0]    rsp_temperature;
   logic [SAMPLE_W-1:0]  rsp_average_reading;
   logic [STATUS_W-1:0]  rsp_range_status;
   logic [CHANNEL_W-1:0] rsp_channel_tag;

   sample_item_type sample_q[$];
   reading_type     reading_q[$];

   int unsigned burst_pos = 0;
   int unsigned burst_sum = 0;

   int errors = 0;
   int cycles = 0;
   int items_taken = 0;
   int readings_checked = 0;
   int restarts_taken = 0;
   int status_seen[3] = '{0, 0, 0};

   ntc_average_and_lut_temperature_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_sample          (req_sample),
      .req_channel         (req_channel),
      .req_restart         (req_restart),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_temperature     (rsp_temperature),
      .rsp_average_reading (rsp_average_reading),
      .rsp_range_status    (rsp_range_status),
      .rsp_channel_tag     (rsp_channel_tag)
   );

   always #10 clock = ~clock;

   task automatic report(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic reading_type to_celsius(input logic [SAMPLE_W-1:0] avg);
      reading_type r;
      int hi, lo;
      bit found;
      r.average = avg;
      r.channel = '0;
      r.temperature = '0;
      r.status = STATUS_INTERP;
      found = 0;
      if (avg >= POINT_READING[0]) begin
         r.status = STATUS_COLD;
      end else if (avg <= POINT_READING[TABLE_POINTS-1]) begin
         r.temperature = TEMP_W'(TEMP_MAX);
         r.status = STATUS_HOT;
      end else begin
         for (int k = 0; k + 1 < TABLE_POINTS; k++) begin
            hi = POINT_READING[k];
            lo = POINT_READING[k+1];
            if (!found && avg <= hi && avg > lo) begin
               found = 1;
               r.temperature = TEMP_W'(k * DEGREES_PER_STEP);
               if (hi != lo)
                  r.temperature = TEMP_W'(k * DEGREES_PER_STEP
                                  + ((hi - int'(avg)) * DEGREES_PER_STEP) / (hi - lo));
            end
         end
      end
      return r;
   endfunction

   task automatic take_sample(input logic [SAMPLE_W-1:0] sample,
                              input logic [CHANNEL_W-1:0] channel, input logic restart);
      reading_type r;
      if (restart) begin
         burst_pos = 0;
         burst_sum = 0;
         restarts_taken++;
      end
      if (burst_pos == 0) begin
         burst_pos = 1;
      end else begin
         burst_sum += sample;
         burst_pos++;
         if (burst_pos == BURST_LEN) begin
            r = to_celsius(SAMPLE_W'(burst_sum / SAMPLES_AVERAGED_DEF));
            r.channel = channel;
            reading_q.push_back(r);
            burst_pos = 0;
            burst_sum = 0;
         end
      end
   endtask

   function automatic void add_item(input int sample, input int channel, input bit restart,
                                    input bit hold);
      sample_item_type it;
      it.sample = SAMPLE_W'(sample);
      it.channel = CHANNEL_W'(channel);
      it.restart = restart;
      it.hold = hold;
      sample_q.push_back(it);
   endfunction

   // first (discarded) sample, then 'kept' samples, averaging to target if not noisy and all 8 kept
   function automatic void add_burst(input int target, input bit noisy, input bit restart_first,
                                     input bit hold, input int kept);
      int s[8];
      int r, d, maxd, j;
      for (int i = 0; i < 8; i++) s[i] = target;
      maxd = target;
      if (4095 - target < maxd) maxd = 4095 - target;
      if (maxd > 60) maxd = 60;
      for (int i = 0; i < 4; i++) begin
         d = $urandom_range(0, maxd);
         s[2*i] += d;
         s[2*i+1] -= d;
      end
      r = (target == 4095) ? 0 : $urandom_range(0, 7);
      j = 0;
      while (r > 0) begin
         if (s[j] < 4095) begin
            s[j]++;
            r--;
         end
         j = (j + 1) % 8;
      end
      add_item($urandom_range(0, 4095), $urandom_range(0, 17), restart_first, hold);
      for (int i = 0; i < kept; i++)
         add_item(noisy ? $urandom_range(0, 4095) : s[i], $urandom_range(0, 17), 1'b0, 1'b0);
   endfunction

   // sender: bursts of items with random gaps
   int burst_left = 0;
   int gap_left = 0;
   sample_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            take_sample(req_sample, req_channel, req_restart);
            items_taken++;
         end
         if (req_push && req_full) begin
            // hold the offered item
         end else if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (sample_q.size() == 0 || (sample_q[0].hold && reading_q.size() != 0)) begin
            req_push <= 1'b0;
         end else begin
            next_item = sample_q.pop_front();
            req_sample <= next_item.sample;
            req_channel <= next_item.channel;
            req_restart <= next_item.restart;
            req_push <= 1'b1;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 25);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // receiver: stall pattern changes by phase
   int stall_mode = 0;
   int phase_left = 0;
   reading_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (reading_q.size() == 0) begin
               report("unexpected result, temperature", rsp_temperature, -1);
            end else begin
               want = reading_q.pop_front();
               readings_checked++;
               if (want.status < 3) status_seen[want.status]++;
               if (rsp_temperature !== want.temperature)
                  report("temperature", rsp_temperature, want.temperature);
               if (rsp_average_reading !== want.average)
                  report("average_reading", rsp_average_reading, want.average);
               if (rsp_range_status !== want.status)
                  report("range_status", rsp_range_status, want.status);
               if (rsp_channel_tag !== want.channel)
                  report("channel_tag", rsp_channel_tag, want.channel);
            end
         end
         if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 300);
         end else begin
            phase_left--;
         end
         case (stall_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom_range(0, 1));
            default: rsp_pop <= (phase_left % 16) == 0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, reading_q.size());
         $display("FAIL");
         $finish;
      end
   end

   int bursts;
   int pick;
   int target;
   bit broken;

   initial begin
      // hot clamp at average 0, first sample at full scale is dropped
      add_item(4095, 3, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) add_item(0, 17, 1'b0, 1'b0);
      // restart mid burst, then cold clamp at full scale
      add_item(0, 1, 1'b0, 1'b0);
      for (int i = 0; i < 3; i++) add_item(4095, 2, 1'b0, 1'b0);
      add_item(0, 5, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) add_item(4095, 16, 1'b0, 1'b0);

      bursts = 0;
      broken = 0;
      while (sample_q.size() < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 3)
            target = POINT_READING[$urandom_range(0, TABLE_POINTS - 1)]
                   + $urandom_range(0, 4) - 2;
         else if (pick == 4)
            target = $urandom_range(0, 1) ? $urandom_range(0, 170) : $urandom_range(3400, 4095);
         else
            target = $urandom_range(0, 4095);
         add_burst(target, pick == 9, broken || $urandom_range(0, 9) == 0,
                   bursts == 60 || bursts == 120,
                   ($urandom_range(0, 14) == 0) ? $urandom_range(0, 7) : 8);
         broken = (sample_q[$].restart == 1'b0) && ($urandom_range(0, 14) == 0);
         bursts++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (sample_q.size() != 0 || req_push) @(posedge clock);
      while (reading_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      while (reading_q.size() != 0) begin
         want = reading_q.pop_front();
         report("missing result, average_reading", -1, want.average);
      end
      $display("%0d samples sent (%0d with restart), %0d readings checked",
               items_taken, restarts_taken, readings_checked);
      $display("interpolated %0d, cold/open %0d, hot/short %0d, %0d mismatches",
               status_seen[0], status_seen[1], status_seen[2], errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
